/* src/ipck_pkg.sv */
// shared types and constants for the ip checksum and tcp tracker
`timescale 1ns / 1ps
package ipck_pkg;
    localparam int TABLE_ENTRIES   = 16;
    localparam int MAX_FRAME_WORDS = 1024;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int POS_W  = $clog2(MAX_FRAME_WORDS + 1);

    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [7:0]  PROTO_TCP = 8'h06;
    localparam logic [15:0] IP_HDR_LEN = 16'h0014;

    localparam logic [2:0] OC_IP    = 3'd0;
    localparam logic [2:0] OC_UDP   = 3'd1;
    localparam logic [2:0] OC_TCP   = 3'd2;
    localparam logic [2:0] OC_UNK   = 3'd3;
    localparam logic [2:0] OC_FULL  = 3'd4;
    localparam logic [2:0] OC_SHORT = 3'd5;

    typedef struct packed {
        logic take;      // accept a frame word
        logic search;    // advance the table scan
        logic finish;    // apply outcome and load result
        logic clear;     // clear per-frame state and scan
    } ipck_cmd_t;

    typedef struct packed {
        logic       is_tcp_ok;   // last word: tcp frame that needs the table
        logic       scan_done;
    } ipck_sts_t;
endpackage

/* src/ipck_ctrl.sv */
// controller: accepts words, runs the table scan, hands off the result
`timescale 1ns / 1ps
module ipck_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_is_last,
    output logic                 s_ready,
    input  logic                 out_full,
    input  ipck_pkg::ipck_sts_t  sts,
    output ipck_pkg::ipck_cmd_t  cmd
);
    localparam logic [1:0] ST_RX   = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_RX: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (s_is_last) state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.search = 1'b1;
                if (sts.scan_done || !sts.is_tcp_ok) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_full) begin
                    cmd.finish = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_RX;
                end
            end
            default: state_next = ST_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

/* src/ipck_datapath.sv */
// datapath: checksum accumulators, connection table and result register
`timescale 1ns / 1ps
module ipck_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ipck_pkg::ipck_cmd_t  cmd,
    output ipck_pkg::ipck_sts_t  sts,
    input  logic [15:0]          s_frame_word,
    output logic                 out_full,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [15:0]          m_ip_sum,
    output logic [15:0]          m_l4_sum,
    output logic [2:0]           m_outcome,
    output logic [3:0]           m_slot,
    output logic                 m_opened,
    output logic                 m_closed
);
    localparam int N  = ipck_pkg::TABLE_ENTRIES;
    localparam int SW = ipck_pkg::SLOT_W;
    localparam int PW = ipck_pkg::POS_W;

    logic [PW-1:0] pos_reg;
    logic [19:0]   hdr_reg;
    logic [31:0]   pay_reg;
    logic [18:0]   pse_reg;
    logic [7:0]    proto_reg;
    logic [15:0]   len_reg;
    logic [31:0]   daddr_reg;
    logic [15:0]   sport_reg, dport_reg;
    logic [1:0]    flags_reg;

    logic [N-1:0]  cv_reg;
    logic [31:0]   ca_reg [N];
    logic [15:0]   cp_reg [N];

    logic [SW:0]   idx_reg;
    logic          hit_reg, free_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;

    logic [15:0] w;
    assign w = s_frame_word;

    // per-word accumulation
    function automatic logic [31:0] l4_add(input logic [31:0] acc, input logic [15:0] len,
                                          input logic [PW:0] wpos, input logic [15:0] v);
        logic [16:0] b;
        logic [15:0] vv;
        b  = 17'((wpos - 17) * 2);
        vv = v;
        if (b < {1'b0, len}) begin
            if (b + 17'd1 == {1'b0, len}) vv = {v[15:8], 8'h00};
            return acc + {16'h0, vv};
        end
        return acc;
    endfunction

    logic [PW:0] p;
    logic [31:0] pay_n;
    logic [15:0] len_n;
    always_comb begin
        p = {1'b0, pos_reg};
        len_n = len_reg;
        pay_n = pay_reg;
        if (p == 8) len_n = w - ipck_pkg::IP_HDR_LEN;
        if (p >= 17) begin
            if (proto_reg == ipck_pkg::PROTO_TCP) begin
                pay_n = l4_add(pay_reg, len_reg, p, (p == 25) ? 16'h0 : w);
            end else if (proto_reg == ipck_pkg::PROTO_UDP) begin
                if (p == 19) begin
                    len_n = w;
                    pay_n = l4_add(pay_reg, w, (PW+1)'(17), sport_reg);
                    pay_n = l4_add(pay_n, w, (PW+1)'(18), dport_reg);
                    pay_n = l4_add(pay_n, w, (PW+1)'(19), w);
                end else if (p > 19) begin
                    pay_n = l4_add(pay_reg, len_reg, p, (p == 20) ? 16'h0 : w);
                end
            end
        end
    end

    // short-frame and protocol checks
    logic [16:0] need;
    logic        cnt_lt17, udp_ok, tcp_ok;
    assign need     = 17'd17 + 17'(({1'b0, len_reg} + 17'd1) >> 1);
    assign cnt_lt17 = pos_reg < PW'(17);
    assign udp_ok   = !cnt_lt17 && proto_reg == ipck_pkg::PROTO_UDP
                      && pos_reg >= PW'(21) && 17'(pos_reg) >= need;
    assign tcp_ok   = !cnt_lt17 && proto_reg == ipck_pkg::PROTO_TCP
                      && pos_reg >= PW'(27) && 17'(pos_reg) >= need;
    assign sts.is_tcp_ok = tcp_ok;
    assign sts.scan_done = idx_reg == (SW+1)'(N);

    // checksum folding
    function automatic logic [15:0] fold(input logic [31:0] s);
        logic [31:0] t;
        t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
        return t[15:0];
    endfunction

    logic [31:0] l4_tot;
    logic [15:0] l4_f, ip_f;
    always_comb begin
        l4_tot = {13'h0, pse_reg} + {24'h0, proto_reg} + {16'h0, len_reg} + pay_reg;
        l4_f   = fold(l4_tot) ^ 16'hFFFF;
        if (l4_f == 16'h0) l4_f = 16'hFFFF;
        ip_f   = fold({12'h0, hdr_reg}) ^ 16'hFFFF;
    end

    logic [SW-1:0] cur;
    assign cur = idx_reg[SW-1:0];

    // result decision
    logic [2:0]    oc;
    logic          op, cl, use_hit;
    logic [SW-1:0] use_idx;
    always_comb begin
        oc = ipck_pkg::OC_IP;
        op = 1'b0;
        cl = 1'b0;
        use_hit = 1'b0;
        use_idx = hit_idx_reg;
        if (cnt_lt17) begin
            oc = ipck_pkg::OC_SHORT;
        end else if (proto_reg == ipck_pkg::PROTO_UDP) begin
            oc = udp_ok ? ipck_pkg::OC_UDP : ipck_pkg::OC_SHORT;
        end else if (proto_reg == ipck_pkg::PROTO_TCP) begin
            if (!tcp_ok) begin
                oc = ipck_pkg::OC_SHORT;
            end else if (flags_reg[1]) begin
                if (hit_reg || free_reg) begin
                    use_hit = 1'b1;
                    use_idx = hit_reg ? hit_idx_reg : free_idx_reg;
                    op = 1'b1;
                    oc = ipck_pkg::OC_TCP;
                end else begin
                    oc = ipck_pkg::OC_FULL;
                end
            end else if (hit_reg) begin
                use_hit = 1'b1;
                cl = flags_reg[0];
                oc = ipck_pkg::OC_TCP;
            end else begin
                oc = ipck_pkg::OC_UNK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; hdr_reg <= '0; pay_reg <= '0; pse_reg <= '0;
            proto_reg <= '0; len_reg <= '0; daddr_reg <= '0;
            sport_reg <= '0; dport_reg <= '0; flags_reg <= '0;
            cv_reg <= '0;
            idx_reg <= '0; hit_reg <= 1'b0; free_reg <= 1'b0;
            hit_idx_reg <= '0; free_idx_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.take && pos_reg < PW'(ipck_pkg::MAX_FRAME_WORDS)) begin
                pos_reg <= pos_reg + PW'(1);
                if (p >= 7 && p <= 16 && p != 12) hdr_reg <= hdr_reg + {4'h0, w};
                if (p >= 13 && p <= 16) pse_reg <= pse_reg + {3'h0, w};
                len_reg <= len_n;
                pay_reg <= pay_n;
                if (p == 11) proto_reg <= w[7:0];
                if (p == 15) daddr_reg[31:16] <= w;
                if (p == 16) daddr_reg[15:0] <= w;
                if (p == 17) sport_reg <= w;
                if (p == 18) dport_reg <= w;
                if (p == 23) flags_reg <= w[1:0];
            end
            if (cmd.search && !sts.scan_done) begin
                idx_reg <= idx_reg + (SW+1)'(1);
                if (!hit_reg && cv_reg[cur] && ca_reg[cur] == daddr_reg
                    && cp_reg[cur] == dport_reg) begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= cur;
                end
                if (!free_reg && !cv_reg[cur]) begin
                    free_reg <= 1'b1;
                    free_idx_reg <= cur;
                end
            end
            if (cmd.finish) begin
                m_valid <= 1'b1;
                if (use_hit) cv_reg[use_idx] <= !cl;
            end
            if (cmd.clear) begin
                pos_reg <= '0; hdr_reg <= '0; pay_reg <= '0; pse_reg <= '0;
                proto_reg <= '0; len_reg <= '0; daddr_reg <= '0;
                sport_reg <= '0; dport_reg <= '0; flags_reg <= '0;
                idx_reg <= '0; hit_reg <= 1'b0; free_reg <= 1'b0;
            end
        end
    end

    // table contents and result payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                ca_reg[i] <= '0;
                cp_reg[i] <= '0;
            end
        end else if (cmd.finish && op) begin
            ca_reg[use_idx] <= daddr_reg;
            cp_reg[use_idx] <= dport_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_ip_sum  <= cnt_lt17 ? 16'h0 : ip_f;
            m_l4_sum  <= (oc == ipck_pkg::OC_UDP || oc == ipck_pkg::OC_TCP) ? l4_f : 16'h0;
            m_outcome <= oc;
            m_slot    <= (oc == ipck_pkg::OC_TCP) ? 4'(use_idx) : 4'h0;
            m_opened  <= op;
            m_closed  <= cl;
        end
    end

    assign out_full = m_valid && !m_ready;
endmodule

/* src/ip_checksum_and_tcp_tracker_core.sv */
// top level of the ip checksum and tcp connection tracker
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one 16-bit big-endian frame word per transaction, s_is_last
//   marks the final word. Words past the frame limit are dropped.
//   m_ channel: one result transaction per frame, with the ip header sum,
//   the udp/tcp sum, an outcome code, table slot and open/close flags.
// Flow:
//   frame words are taken at one per cycle while s_ready is high. After the
//   last word the controller passes through its scan state, which for
//   complete tcp frames scans every table entry, then its done state, which
//   loads the output register; no new frame's words are taken meanwhile.
// Reset:
//   aresetn clears per-frame state and the connection table at once.
// Stall:
//   when the receiver holds m_ready low the result stays in the output
//   register and the next frame's words are taken up to and including
//   its last word; s_ready then stays low until the register frees up.
module ip_checksum_and_tcp_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_frame_word,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_ip_sum,
    output logic [15:0] m_l4_sum,
    output logic [2:0]  m_outcome,
    output logic [3:0]  m_slot,
    output logic        m_opened,
    output logic        m_closed
);
    ipck_pkg::ipck_cmd_t cmd;
    ipck_pkg::ipck_sts_t sts;
    logic out_full;

    ipck_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_is_last(s_is_last),
        .s_ready(s_ready), .out_full(out_full), .sts(sts), .cmd(cmd)
    );

    ipck_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_frame_word(s_frame_word), .out_full(out_full), .m_ready(m_ready),
        .m_valid(m_valid), .m_ip_sum(m_ip_sum), .m_l4_sum(m_l4_sum),
        .m_outcome(m_outcome), .m_slot(m_slot), .m_opened(m_opened),
        .m_closed(m_closed)
    );
endmodule

/* src/ipck_checker.sv */
// port-level checks for the ip checksum and tcp tracker
`timescale 1ns / 1ps
module ipck_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_l4_sum,
    input logic [2:0]  m_outcome,
    input logic [3:0]  m_slot,
    input logic        m_opened,
    input logic        m_closed
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_outcome))
        else $error("result changed under stall");
    a_no_l4: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_outcome == ipck_pkg::OC_UDP || m_outcome == ipck_pkg::OC_TCP)
        |-> m_l4_sum == 16'h0)
        else $error("l4 sum without l4 outcome");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_opened && m_closed))
        else $error("open and close together");
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome != ipck_pkg::OC_TCP |-> m_slot == 4'h0 && !m_opened && !m_closed)
        else $error("slot outside tcp outcome");
endmodule

bind ip_checksum_and_tcp_tracker_core ipck_checker u_ipck_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_l4_sum(m_l4_sum), .m_outcome(m_outcome), .m_slot(m_slot),
    .m_opened(m_opened), .m_closed(m_closed)
);
